/* rtl/cdt_pkg.sv */
// Shared types, register indexes and command codes of the countdown timer controller.
package cdt_pkg;

  localparam int unsigned TimeW    = 16;
  localparam int unsigned TickW    = 10;
  localparam int unsigned StepW    = 14;
  localparam int unsigned LedCntW  = 3;
  localparam int unsigned ModeW    = 3;
  localparam int unsigned MaskW    = 5;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned TotalW   = LedCntW + StepW;

  // Number of LEDs the countdown can drive; a larger led_count is clipped to it.
  localparam logic [4:0] MaxLeds = 5'd5;

  localparam logic [TimeW-1:0] TimeMax = {TimeW{1'b1}};

  typedef enum logic [CfgIdxW-1:0] {
    REG_TICK_PERIOD  = 3'd0,
    REG_STEP_PERIOD  = 3'd1,
    REG_BLINK_PERIOD = 3'd2,
    REG_LONG_PRESS   = 3'd3,
    REG_LED_COUNT    = 3'd4
  } cdt_reg_e;

  typedef enum logic [7:0] {
    CMD_GO     = 8'h67,
    CMD_PAUSE  = 8'h70,
    CMD_RESUME = 8'h72,
    CMD_ESCAPE = 8'h65,
    CMD_SAVE   = 8'h73,
    CMD_CONFIG = 8'h63
  } cdt_cmd_e;

  // One-hot state codes; the code of each state is also its LED mask.
  typedef enum logic [MaskW-1:0] {
    MODE_START     = 5'b00001,
    MODE_COUNTDOWN = 5'b00010,
    MODE_FREEZE    = 5'b00100,
    MODE_BLINK     = 5'b01000,
    MODE_CONFIG    = 5'b10000
  } cdt_mode_e;

  typedef struct packed {
    logic [TickW-1:0]   tick_period_ms;
    logic [StepW-1:0]   step_period_ms;
    logic [TimeW-1:0]   blink_period_ms;
    logic [TimeW-1:0]   long_press_ms;
    logic [LedCntW-1:0] led_count;
  } cdt_cfg_t;

  typedef struct packed {
    logic       go_pressed;
    logic       escape_pressed;
    logic       more_pressed;
    logic       command_valid;
    logic [7:0] command_char;
  } cdt_tick_t;

  function automatic logic [ModeW-1:0] mode_index(cdt_mode_e m);
    logic [ModeW-1:0] idx;
    idx = '0;
    unique case (m)
      MODE_START:     idx = 3'd0;
      MODE_COUNTDOWN: idx = 3'd1;
      MODE_FREEZE:    idx = 3'd2;
      MODE_BLINK:     idx = 3'd3;
      MODE_CONFIG:    idx = 3'd4;
      default:        idx = 3'd0;
    endcase
    return idx;
  endfunction

  function automatic logic [TimeW-1:0] sat_add(logic [TimeW-1:0] a, logic [TickW-1:0] b);
    logic [TimeW:0] s;
    s = {1'b0, a} + {{(TimeW + 1 - TickW){1'b0}}, b};
    return s[TimeW] ? TimeMax : s[TimeW-1:0];
  endfunction

endpackage

/* rtl/cdt_in_if.sv */
// Input channel: one control tick per beat.
interface cdt_in_if;
  logic       valid;
  logic       ready;
  logic       go_pressed;
  logic       escape_pressed;
  logic       more_pressed;
  logic       command_valid;
  logic [7:0] command_char;

  modport source (output valid, go_pressed, escape_pressed, more_pressed, command_valid,
                  command_char, input ready);
  modport sink (input valid, go_pressed, escape_pressed, more_pressed, command_valid,
                command_char, output ready);
endinterface

/* rtl/cdt_out_if.sv */
// Output channel: the mode and LED mask after each tick.
interface cdt_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] mode;
  logic [4:0] led_mask;

  modport source (output valid, mode, led_mask, input ready);
  modport sink (input valid, mode, led_mask, output ready);
endinterface

/* rtl/cdt_cfg_regs.sv */
// Configuration register file with reset values and index decode.
module cdt_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cdt_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [cdt_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output cdt_pkg::cdt_cfg_t             cfg_o
);

  cdt_pkg::cdt_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cdt_pkg::cdt_reg_e'(cfg_idx_i))
        cdt_pkg::REG_TICK_PERIOD:  cfg_d.tick_period_ms  = cfg_wdata_i[cdt_pkg::TickW-1:0];
        cdt_pkg::REG_STEP_PERIOD:  cfg_d.step_period_ms  = cfg_wdata_i[cdt_pkg::StepW-1:0];
        cdt_pkg::REG_BLINK_PERIOD: cfg_d.blink_period_ms = cfg_wdata_i;
        cdt_pkg::REG_LONG_PRESS:   cfg_d.long_press_ms   = cfg_wdata_i;
        cdt_pkg::REG_LED_COUNT:    cfg_d.led_count       = cfg_wdata_i[cdt_pkg::LedCntW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tick_period_ms  <= 10'd50;
      cfg_q.step_period_ms  <= 14'd2000;
      cfg_q.blink_period_ms <= 16'd10000;
      cfg_q.long_press_ms   <= 16'd3000;
      cfg_q.led_count       <= 3'd5;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/cdt_core.sv */
// Mode state machine with edge detection, hold timer and time-in-mode counter.
module cdt_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cdt_pkg::cdt_cfg_t   cfg_i,
  input  cdt_pkg::cdt_tick_t  tick_i,
  input  logic                tick_en_i,
  output cdt_pkg::cdt_mode_e  mode_next_o
);

  cdt_pkg::cdt_mode_e mode_q, mode_d;
  logic [cdt_pkg::TimeW-1:0] time_q, time_d, time_inc;
  logic [cdt_pkg::TimeW-1:0] frozen_q, frozen_d;
  logic [cdt_pkg::TimeW-1:0] hold_q, hold_d;
  logic                      hold_active_q, hold_active_d;
  logic [2:0]                prev_q, prev_d;

  logic go_edge, esc_edge, go_cmd, long_hold, timed_out, blink_done;
  logic is_go, is_pause, is_resume, is_escape, is_save, is_config;
  logic resume, pause;
  logic [cdt_pkg::LedCntW-1:0] leds;
  logic [cdt_pkg::TotalW-1:0]  total;

  always_comb begin
    is_go     = tick_i.command_valid && tick_i.command_char == cdt_pkg::CMD_GO;
    is_pause  = tick_i.command_valid && tick_i.command_char == cdt_pkg::CMD_PAUSE;
    is_resume = tick_i.command_valid && tick_i.command_char == cdt_pkg::CMD_RESUME;
    is_escape = tick_i.command_valid && tick_i.command_char == cdt_pkg::CMD_ESCAPE;
    is_save   = tick_i.command_valid && tick_i.command_char == cdt_pkg::CMD_SAVE;
    is_config = tick_i.command_valid && tick_i.command_char == cdt_pkg::CMD_CONFIG;

    go_edge  = tick_i.go_pressed && !prev_q[0];
    esc_edge = tick_i.escape_pressed && !prev_q[1];
    prev_d   = {tick_i.more_pressed, tick_i.escape_pressed, tick_i.go_pressed};

    // The hold timer starts at zero on the first held tick.
    if (tick_i.more_pressed) begin
      hold_active_d = 1'b1;
      hold_d = hold_active_q ? cdt_pkg::sat_add(hold_q, cfg_i.tick_period_ms) : '0;
    end else begin
      hold_active_d = 1'b0;
      hold_d        = '0;
    end

    time_inc = cdt_pkg::sat_add(time_q, cfg_i.tick_period_ms);

    leds = ({2'b00, cfg_i.led_count} > cdt_pkg::MaxLeds) ?
           cdt_pkg::MaxLeds[cdt_pkg::LedCntW-1:0] : cfg_i.led_count;
    total = cdt_pkg::TotalW'(leds) * cdt_pkg::TotalW'(cfg_i.step_period_ms);

    go_cmd     = go_edge || is_go;
    long_hold  = hold_d >= cfg_i.long_press_ms;
    timed_out  = {{(cdt_pkg::TotalW - cdt_pkg::TimeW){1'b0}}, time_inc} >= total;
    blink_done = time_inc >= cfg_i.blink_period_ms;

    mode_d = mode_q;
    resume = 1'b0;
    pause  = 1'b0;
    unique case (mode_q)
      cdt_pkg::MODE_START: begin
        if (go_cmd) begin
          mode_d = cdt_pkg::MODE_COUNTDOWN;
        end else if (long_hold || is_config) begin
          mode_d = cdt_pkg::MODE_CONFIG;
        end
      end
      cdt_pkg::MODE_COUNTDOWN: begin
        if (esc_edge || is_pause) begin
          pause  = 1'b1;
          mode_d = cdt_pkg::MODE_FREEZE;
        end else if (go_cmd || timed_out) begin
          mode_d = cdt_pkg::MODE_BLINK;
        end else if (long_hold || is_config) begin
          mode_d = cdt_pkg::MODE_CONFIG;
        end
      end
      cdt_pkg::MODE_FREEZE: begin
        if (esc_edge || is_resume) begin
          resume = 1'b1;
          mode_d = cdt_pkg::MODE_COUNTDOWN;
        end else if (long_hold || is_config) begin
          mode_d = cdt_pkg::MODE_CONFIG;
        end
      end
      cdt_pkg::MODE_BLINK: begin
        if (go_cmd || blink_done) begin
          mode_d = cdt_pkg::MODE_START;
        end else if (long_hold || is_config) begin
          mode_d = cdt_pkg::MODE_CONFIG;
        end
      end
      cdt_pkg::MODE_CONFIG: begin
        if (esc_edge || is_escape || long_hold || is_save) begin
          mode_d = cdt_pkg::MODE_START;
        end
      end
      default: mode_d = cdt_pkg::MODE_START;
    endcase

    frozen_d = pause ? time_inc : frozen_q;

    // Every change of mode restarts the clock, except a resume, which picks up
    // the time saved when the countdown was paused.
    if (mode_d != mode_q) begin
      time_d = resume ? frozen_q : '0;
    end else begin
      time_d = time_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= cdt_pkg::MODE_START;
      time_q        <= '0;
      frozen_q      <= '0;
      hold_q        <= '0;
      hold_active_q <= 1'b0;
      prev_q        <= '0;
    end else if (tick_en_i) begin
      mode_q        <= mode_d;
      time_q        <= time_d;
      frozen_q      <= frozen_d;
      hold_q        <= hold_d;
      hold_active_q <= hold_active_d;
      prev_q        <= prev_d;
    end
  end

  assign mode_next_o = mode_d;

endmodule

/* rtl/countdown_timer_controller.sv */
// Top level of the countdown timer controller: channels, configuration and result register.
//
//   channel   direction  beat contents
//   in_s      in         go, escape, more button levels; command_valid, command_char
//   out_m     out        mode (3 bits), led_mask (5 bits)
//   cfg_*     in         register index and write data, one write per cycle
//
// Each accepted tick's result appears in the result register on the next cycle; a tick can be
// accepted every cycle while no result waits unread or the waiting result is being taken.
// The state machine and its timers update in the same edge that accepts the beat.
// While a result waits unread, the input is held off and is accepted only as the result is taken.
// Reset puts the block in the start mode with all timers cleared.
module countdown_timer_controller (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cdt_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [cdt_pkg::CfgDataW-1:0]  cfg_wdata_i,
  cdt_in_if.sink                        in_s,
  cdt_out_if.source                     out_m
);

  cdt_pkg::cdt_cfg_t  cfg;
  cdt_pkg::cdt_tick_t tick;
  cdt_pkg::cdt_mode_e mode_next;

  logic                       accept;
  logic                       out_valid_q;
  logic [cdt_pkg::ModeW-1:0]  mode_q;
  logic [cdt_pkg::MaskW-1:0]  mask_q;

  assign tick.go_pressed     = in_s.go_pressed;
  assign tick.escape_pressed = in_s.escape_pressed;
  assign tick.more_pressed   = in_s.more_pressed;
  assign tick.command_valid  = in_s.command_valid;
  assign tick.command_char   = in_s.command_char;

  assign in_s.ready = !out_valid_q || out_m.ready;
  assign accept     = in_s.valid && in_s.ready;

  cdt_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  cdt_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .tick_i      (tick),
    .tick_en_i   (accept),
    .mode_next_o (mode_next)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_m.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // The one-hot state code doubles as the LED mask.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= cdt_pkg::mode_index(mode_next);
      mask_q <= mode_next;
    end
  end

  assign out_m.valid    = out_valid_q;
  assign out_m.mode     = mode_q;
  assign out_m.led_mask = mask_q;

endmodule
